>>> design/omtc_pkg.sv
// shared types, codes and the transition rule table of the mode controller
// no dependencies
package omtc_pkg;

   localparam int MODE_W  = 3;
   localparam int CMD_W   = 3;
   localparam int EVENT_W = 5;
   localparam int STAT_W  = 2;
   localparam int OUT_W   = 32;

   localparam int COUNT_BITS_DEF = 32;
   localparam int TIME_BITS_DEF  = 32;

   // operating modes
   localparam logic [MODE_W-1:0] MODE_BOOT      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SAFE      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DETUMBLE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ACTIVE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_EMERGENCY = 3'd5;
   localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd6;
   localparam logic [MODE_W-1:0] NO_RULE        = 3'd7;

   // commands
   localparam logic [CMD_W-1:0] CMD_APPLY   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FORCE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_EVENT = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_RULE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_MODE  = 2'd3;

   // events
   localparam logic [3:0] EV_NONE           = 4'd0;
   localparam logic [3:0] EV_BOOT_DONE      = 4'd1;
   localparam logic [3:0] EV_DETUMBLE_DONE  = 4'd2;
   localparam logic [3:0] EV_COMM_ACQUIRED  = 4'd3;
   localparam logic [3:0] EV_POWER_OK       = 4'd4;
   localparam logic [3:0] EV_POWER_LOW      = 4'd5;
   localparam logic [3:0] EV_POWER_CRIT     = 4'd6;
   localparam logic [3:0] EV_THERMAL_FAULT  = 4'd7;
   localparam logic [3:0] EV_COMM_TIMEOUT   = 4'd8;
   localparam logic [3:0] EV_WATCHDOG       = 4'd9;
   localparam logic [3:0] EV_GROUND_SAFE    = 4'd10;
   localparam logic [3:0] EV_GROUND_IDLE    = 4'd11;
   localparam logic [3:0] EV_GROUND_ACTIVE  = 4'd12;
   localparam logic [3:0] EV_AI_READY       = 4'd13;
   localparam logic [3:0] EV_AI_FAULT       = 4'd14;
   localparam logic [3:0] EV_RECOVERY_OK    = 4'd15;

   typedef struct packed {
      logic [CMD_W-1:0]   mode;
      logic [EVENT_W-1:0] event_code;
      logic [MODE_W-1:0]  target_mode;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0] current_mode;
      logic [MODE_W-1:0] prior_mode;
      logic [OUT_W-1:0]  transition_total;
      logic [OUT_W-1:0]  time_in_mode;
      logic [STAT_W-1:0] status;
      logic              transition_valid;
   } rsp_type;

   // next mode for a (mode, event) pair, NO_RULE when nothing matches
   function automatic logic [MODE_W-1:0] rule_target(input logic [MODE_W-1:0]  from,
                                                     input logic [EVENT_W-1:0] ev);
      logic [MODE_W-1:0] to;
      logic [3:0]        e;
      to = NO_RULE;
      e  = ev[3:0];
      if (ev[EVENT_W-1] == 1'b0) begin
         unique case (from)
            MODE_BOOT: begin
               unique case (e)
                  EV_BOOT_DONE:  to = MODE_DETUMBLE;
                  EV_POWER_CRIT: to = MODE_SAFE;
                  default:       to = NO_RULE;
               endcase
            end
            MODE_SAFE: begin
               unique case (e)
                  EV_POWER_OK, EV_GROUND_IDLE, EV_RECOVERY_OK: to = MODE_IDLE;
                  default:                                     to = NO_RULE;
               endcase
            end
            MODE_DETUMBLE: begin
               unique case (e)
                  EV_DETUMBLE_DONE: to = MODE_IDLE;
                  EV_POWER_LOW, EV_POWER_CRIT, EV_WATCHDOG, EV_GROUND_SAFE:
                                    to = MODE_SAFE;
                  default:          to = NO_RULE;
               endcase
            end
            MODE_IDLE: begin
               unique case (e)
                  EV_POWER_LOW, EV_POWER_CRIT, EV_THERMAL_FAULT, EV_COMM_TIMEOUT,
                  EV_WATCHDOG, EV_GROUND_SAFE:
                                               to = MODE_SAFE;
                  EV_GROUND_ACTIVE, EV_AI_READY: to = MODE_ACTIVE;
                  default:                     to = NO_RULE;
               endcase
            end
            MODE_ACTIVE: begin
               unique case (e)
                  EV_POWER_LOW, EV_COMM_TIMEOUT, EV_GROUND_IDLE, EV_AI_FAULT:
                     to = MODE_IDLE;
                  EV_POWER_CRIT, EV_THERMAL_FAULT, EV_WATCHDOG, EV_GROUND_SAFE:
                     to = MODE_SAFE;
                  default:
                     to = NO_RULE;
               endcase
            end
            MODE_EMERGENCY: begin
               unique case (e)
                  EV_GROUND_SAFE, EV_RECOVERY_OK: to = MODE_SAFE;
                  default:                        to = NO_RULE;
               endcase
            end
            default: to = NO_RULE;
         endcase
      end
      return to;
   endfunction

endpackage

>>> design/omtc_if.sv
// valid/ready channels of the mode controller: request, response and csr write
// depends on omtc_pkg
interface omtc_req_if;
   import omtc_pkg::*;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   mode;
   logic [EVENT_W-1:0] event_code;
   logic [MODE_W-1:0]  target_mode;
   modport source(output valid, mode, event_code, target_mode, input ready);
   modport sink(input valid, mode, event_code, target_mode, output ready);
endinterface

interface omtc_rsp_if;
   import omtc_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] current_mode;
   logic [MODE_W-1:0] prior_mode;
   logic [OUT_W-1:0]  transition_total;
   logic [OUT_W-1:0]  time_in_mode;
   logic [STAT_W-1:0] status;
   logic              transition_valid;
   modport source(output valid, current_mode, prior_mode, transition_total,
                  time_in_mode, status, transition_valid, input ready);
   modport sink(input valid, current_mode, prior_mode, transition_total,
                time_in_mode, status, transition_valid, output ready);
endinterface

interface omtc_csr_if;
   import omtc_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

>>> design/omtc_step.sv
// next-state and response logic for one request of the mode controller
// depends on omtc_pkg
module omtc_step #(
   parameter int COUNT_BITS = omtc_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = omtc_pkg::TIME_BITS_DEF
) (
   input  omtc_pkg::req_type                 item,
   input  logic [omtc_pkg::MODE_W-1:0]       initial_mode,
   input  logic [omtc_pkg::MODE_W-1:0]       mode_now,
   input  logic [omtc_pkg::MODE_W-1:0]       mode_before,
   input  logic [COUNT_BITS-1:0]             count,
   input  logic [TIME_BITS-1:0]              timer,
   output logic [omtc_pkg::MODE_W-1:0]       mode_now_nxt,
   output logic [omtc_pkg::MODE_W-1:0]       mode_before_nxt,
   output logic [COUNT_BITS-1:0]             count_nxt,
   output logic [TIME_BITS-1:0]              timer_nxt,
   output omtc_pkg::rsp_type                 rsp
);
   import omtc_pkg::*;

   logic [MODE_W-1:0] rule_to;
   logic [STAT_W-1:0] status;
   logic              check_ok;
   logic [63:0]       count_wide;
   logic [63:0]       timer_wide;

   assign rule_to = rule_target(mode_now, item.event_code);

   always_comb begin
      mode_now_nxt    = mode_now;
      mode_before_nxt = mode_before;
      count_nxt       = count;
      timer_nxt       = timer;
      status          = ST_OK;
      check_ok        = 1'b0;
      unique case (item.mode)
         CMD_APPLY: begin
            if (item.event_code[EVENT_W-1]) begin
               status = ST_BAD_EVENT;
            end else if (rule_to == NO_RULE) begin
               status = ST_NO_RULE;
            end else begin
               mode_before_nxt = mode_now;
               mode_now_nxt    = rule_to;
               count_nxt       = count + COUNT_BITS'(1);
               timer_nxt       = '0;
            end
         end
         CMD_FORCE: begin
            if (item.target_mode >= MODE_COUNT) begin
               status = ST_BAD_MODE;
            end else begin
               mode_before_nxt = mode_now;
               mode_now_nxt    = item.target_mode;
               count_nxt       = count + COUNT_BITS'(1);
               timer_nxt       = '0;
            end
         end
         CMD_TICK: begin
            if (timer != '1) begin
               timer_nxt = timer + TIME_BITS'(1);
            end
         end
         CMD_CHECK: begin
            check_ok = (rule_to != NO_RULE);
         end
         CMD_RESTART: begin
            if (initial_mode >= MODE_COUNT) begin
               status = ST_BAD_MODE;
            end else begin
               mode_now_nxt    = initial_mode;
               mode_before_nxt = initial_mode;
               count_nxt       = '0;
               timer_nxt       = '0;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // responses carry the low 32 bits of the counters, zero extended when narrower
   assign count_wide = 64'(count_nxt);
   assign timer_wide = 64'(timer_nxt);

   always_comb begin
      rsp.current_mode     = mode_now_nxt;
      rsp.prior_mode       = mode_before_nxt;
      rsp.transition_total = count_wide[OUT_W-1:0];
      rsp.time_in_mode     = timer_wide[OUT_W-1:0];
      rsp.status           = status;
      rsp.transition_valid = check_ok;
   end

endmodule

>>> design/operating_mode_transition_controller_top.sv
// top level of the operating mode transition controller
// depends on omtc_pkg, omtc_if and omtc_step
//
// six-mode controller (boot, safe, detumble, idle, active, emergency) driven by
// requests that apply an event, force a mode, count a millisecond tick, check
// whether an event has a rule, or restart at the initial mode held in the csr.
// a request is captured in an input register, the state update and response
// are worked out in one pass of the step logic, and the response lands in an
// output register. one request is taken every cycle when the response side
// keeps up; a request passes the input, then the output register before its
// response is on the response port. the rate is set by the state update loop
// through omtc_step, which reads the mode and counters and writes them back in
// the same clock. a stall on the response side holds the output register and a
// full input register; the input register still takes a new request whenever
// it is empty or its content moves on in the same cycle. the csr port is always
// ready and should only be written while no request is in flight.
module operating_mode_transition_controller_top #(
   parameter int COUNT_BITS = omtc_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = omtc_pkg::TIME_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   omtc_req_if.sink   req_ch,
   omtc_rsp_if.source rsp_ch,
   omtc_csr_if.sink   csr_ch
);
   import omtc_pkg::*;

   // input register
   req_type           req_ff;
   logic              req_valid_ff;
   // output register
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   // controller state
   logic [MODE_W-1:0]     initial_mode_ff;
   logic [MODE_W-1:0]     mode_now_ff;
   logic [MODE_W-1:0]     mode_now_in;
   logic [MODE_W-1:0]     mode_before_ff;
   logic [MODE_W-1:0]     mode_before_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [TIME_BITS-1:0]  timer_ff;
   logic [TIME_BITS-1:0]  timer_in;

   logic advance;
   logic req_take;

   // the output register moves when empty or when its response is taken
   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !req_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // csr write
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_mode_ff <= MODE_BOOT;
      end else if (csr_ch.valid) begin
         initial_mode_ff <= csr_ch.data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         req_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.mode        <= req_ch.mode;
         req_ff.event_code  <= req_ch.event_code;
         req_ff.target_mode <= req_ch.target_mode;
      end
   end

   omtc_step #(
      .COUNT_BITS (COUNT_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_step (
      .item            (req_ff),
      .initial_mode    (initial_mode_ff),
      .mode_now        (mode_now_ff),
      .mode_before     (mode_before_ff),
      .count           (count_ff),
      .timer           (timer_ff),
      .mode_now_nxt    (mode_now_in),
      .mode_before_nxt (mode_before_in),
      .count_nxt       (count_in),
      .timer_nxt       (timer_in),
      .rsp             (rsp_in)
   );

   // state commits when the request moves into the output register;
   // reset loads boot, which is also the reset value of the initial mode
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_now_ff    <= MODE_BOOT;
         mode_before_ff <= MODE_BOOT;
         count_ff       <= '0;
         timer_ff       <= '0;
      end else if (req_valid_ff && advance) begin
         mode_now_ff    <= mode_now_in;
         mode_before_ff <= mode_before_in;
         count_ff       <= count_in;
         timer_ff       <= timer_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.current_mode     = rsp_ff.current_mode;
   assign rsp_ch.prior_mode       = rsp_ff.prior_mode;
   assign rsp_ch.transition_total = rsp_ff.transition_total;
   assign rsp_ch.time_in_mode     = rsp_ff.time_in_mode;
   assign rsp_ch.status           = rsp_ff.status;
   assign rsp_ch.transition_valid = rsp_ff.transition_valid;

endmodule
